>>> rtl/rti_pkg.sv
// Shared types and constants of the ray/triangle intersection block.
`default_nettype none
package rti_pkg;

    localparam int DATA_W = 32;
    localparam int DIFF_W = 33;
    localparam int BARY_W = 17;
    localparam int THR_W  = 16;

    localparam logic OP_RAY = 1'b0;
    localparam logic OP_TRI = 1'b1;

    localparam logic signed [DATA_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DIST_MIN = 32'sh8000_0000;
    localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_U_OUT    = 2'd2,
        ST_V_OUT    = 2'd3
    } status_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  distance;
        logic [BARY_W-1:0]         bary_u;
        logic [BARY_W-1:0]         bary_v;
    } rsp_t;

endpackage
`default_nettype wire

>>> rtl/rti_req_if.sv
// Request channel: ray load or triangle test item.
`default_nettype none
interface rti_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;

    modport source (output valid, op, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, input ready);
    modport sink   (input valid, op, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, output ready);
endinterface
`default_nettype wire

>>> rtl/rti_rsp_if.sv
// Result channel: status, distance and barycentric weights.
`default_nettype none
interface rti_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] distance;
    logic [16:0]        bary_u;
    logic [16:0]        bary_v;

    modport source (output valid, status, distance, bary_u, bary_v, input ready);
    modport sink   (input valid, status, distance, bary_u, bary_v, output ready);
endinterface
`default_nettype wire

>>> rtl/ray_triangle_intersect.sv
// Ray/triangle intersection (Moller-Trumbore) in signed fixed point, fully pipelined.
// The pipeline has 8 arithmetic stages, 32 restoring-divider stages and a two-entry
// output queue. Throughput: one item per cycle while a full queue does not stall it;
// the divider has one stage per quotient bit. Ray items give no result.
// Reset (async, active low) empties pipeline and queue, zeroes the ray, threshold = 1.
`default_nettype none
module ray_triangle_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [rti_pkg::THR_W-1:0] cfg_wdata,
    rti_req_if.sink                   request,
    rti_rsp_if.source                 result
);
    import rti_pkg::*;

    localparam int XW   = 2 * DIFF_W + 1;      // cross product component
    localparam int MW   = 2 * DIFF_W;          // single product
    localparam int LOW_W = DIFF_W;             // low split of cross component
    localparam int HI_W = XW - LOW_W;          // high split, signed
    localparam int PPW  = HI_W + DIFF_W;       // partial product of a dot term
    localparam int DW   = 101;                 // dot products, exact
    localparam int QB   = DATA_W;              // quotient bits
    localparam int RW   = DW + QB + 1;         // divider remainder
    localparam int PRE  = 8;                   // stages before the divider
    localparam int NST  = PRE + QB;

    // ------------------------------------------------------------------
    // flow control and held state
    logic               en;
    logic               acc;
    logic               push;
    logic               pop;
    logic [NST-1:0]     vld_reg;
    logic [1:0]         cnt_reg;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    rsp_t               fifo_reg [2];
    rsp_t               rsp_next;
    logic [THR_W-1:0]   thr_reg;
    logic signed [DATA_W-1:0] ray_org_reg [3];
    logic signed [DATA_W-1:0] ray_dir_reg [3];

    logic signed [DATA_W-1:0] in_a [3];
    logic signed [DATA_W-1:0] in_b [3];
    logic signed [DATA_W-1:0] in_c [3];

    assign in_a[0] = request.first_x;
    assign in_a[1] = request.first_y;
    assign in_a[2] = request.first_z;
    assign in_b[0] = request.second_x;
    assign in_b[1] = request.second_y;
    assign in_b[2] = request.second_z;
    assign in_c[0] = request.third_x;
    assign in_c[1] = request.third_y;
    assign in_c[2] = request.third_z;

    // pipeline moves unless the last stage holds an item and the queue is full
    assign en  = !(vld_reg[NST-1] && (cnt_reg == 2'd2));
    assign acc = request.valid && en;
    assign push = en && vld_reg[NST-1];
    assign pop = result.valid && result.ready;
    assign request.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            thr_reg    <= THR_W'(1);
            for (int i = 0; i < 3; i++)
            begin
                ray_org_reg[i] <= '0;
                ray_dir_reg[i] <= '0;
            end
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[NST-2:0], acc && (request.op == OP_TRI)};
            if (acc && (request.op == OP_RAY))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ray_org_reg[i] <= in_a[i];
                    ray_dir_reg[i] <= in_b[i];
                end
            end
            if (cfg_we)
                thr_reg <= cfg_wdata;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // ------------------------------------------------------------------
    // stage A: edge vectors and ray direction
    logic signed [DIFF_W-1:0] a_d_reg [3];
    logic signed [DIFF_W-1:0] a_e_reg [3];
    logic signed [DIFF_W-1:0] a_f_reg [3];
    logic signed [DIFF_W-1:0] a_t_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_d_reg[i] <= DIFF_W'(ray_dir_reg[i]);
                a_e_reg[i] <= DIFF_W'(in_b[i]) - DIFF_W'(in_a[i]);
                a_f_reg[i] <= DIFF_W'(in_c[i]) - DIFF_W'(in_a[i]);
                a_t_reg[i] <= DIFF_W'(ray_org_reg[i]) - DIFF_W'(in_a[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage B: cross product terms, p = d x f, q = t x e
    logic signed [MW-1:0]     b_pm_reg [3][2];
    logic signed [MW-1:0]     b_qm_reg [3][2];
    logic signed [DIFF_W-1:0] b_d_reg [3];
    logic signed [DIFF_W-1:0] b_e_reg [3];
    logic signed [DIFF_W-1:0] b_f_reg [3];
    logic signed [DIFF_W-1:0] b_t_reg [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_cross
        localparam int C1 = (c + 1) % 3;
        localparam int C2 = (c + 2) % 3;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                b_pm_reg[c][0] <= a_d_reg[C1] * a_f_reg[C2];
                b_pm_reg[c][1] <= a_d_reg[C2] * a_f_reg[C1];
                b_qm_reg[c][0] <= a_t_reg[C1] * a_e_reg[C2];
                b_qm_reg[c][1] <= a_t_reg[C2] * a_e_reg[C1];
                b_d_reg[c] <= a_d_reg[c];
                b_e_reg[c] <= a_e_reg[c];
                b_f_reg[c] <= a_f_reg[c];
                b_t_reg[c] <= a_t_reg[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage C: cross product components
    logic signed [XW-1:0]     c_p_reg [3];
    logic signed [XW-1:0]     c_q_reg [3];
    logic signed [DIFF_W-1:0] c_d_reg [3];
    logic signed [DIFF_W-1:0] c_e_reg [3];
    logic signed [DIFF_W-1:0] c_f_reg [3];
    logic signed [DIFF_W-1:0] c_t_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_p_reg[i] <= XW'(b_pm_reg[i][0]) - XW'(b_pm_reg[i][1]);
                c_q_reg[i] <= XW'(b_qm_reg[i][0]) - XW'(b_qm_reg[i][1]);
                c_d_reg[i] <= b_d_reg[i];
                c_e_reg[i] <= b_e_reg[i];
                c_f_reg[i] <= b_f_reg[i];
                c_t_reg[i] <= b_t_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage D: split dot terms into two narrow products each
    // dot 0: det = p.e, 1: u = p.t, 2: v = q.d, 3: t = q.f
    logic signed [XW-1:0]     dot_x [4][3];
    logic signed [DIFF_W-1:0] dot_y [4][3];
    logic signed [PPW-1:0]    d_plo_reg [4][3];
    logic signed [PPW-1:0]    d_phi_reg [4][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dot_x[0][i] = c_p_reg[i];
            dot_y[0][i] = c_e_reg[i];
            dot_x[1][i] = c_p_reg[i];
            dot_y[1][i] = c_t_reg[i];
            dot_x[2][i] = c_q_reg[i];
            dot_y[2][i] = c_d_reg[i];
            dot_x[3][i] = c_q_reg[i];
            dot_y[3][i] = c_f_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_plo_reg[k][i] <= $signed({1'b0, dot_x[k][i][LOW_W-1:0]})
                                       * dot_y[k][i];
                    d_phi_reg[k][i] <= $signed(dot_x[k][i][XW-1:LOW_W]) * dot_y[k][i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage E: recombine split products
    logic signed [DW-1:0] e_term_reg [4][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int i = 0; i < 3; i++)
                    e_term_reg[k][i] <= (DW'(d_phi_reg[k][i]) <<< LOW_W)
                                        + DW'(d_plo_reg[k][i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage F: dot product sums
    logic signed [DW-1:0] f_dot_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                f_dot_reg[k] <= e_term_reg[k][0] + e_term_reg[k][1] + e_term_reg[k][2];
        end
    end

    // ------------------------------------------------------------------
    // stage G: make the determinant nonnegative
    logic signed [DW-1:0] g_det_reg;
    logic signed [DW-1:0] g_un_reg;
    logic signed [DW-1:0] g_vn_reg;
    logic signed [DW-1:0] g_tn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (f_dot_reg[0][DW-1])
            begin
                g_det_reg <= -f_dot_reg[0];
                g_un_reg  <= -f_dot_reg[1];
                g_vn_reg  <= -f_dot_reg[2];
                g_tn_reg  <= -f_dot_reg[3];
            end
            else
            begin
                g_det_reg <= f_dot_reg[0];
                g_un_reg  <= f_dot_reg[1];
                g_vn_reg  <= f_dot_reg[2];
                g_tn_reg  <= f_dot_reg[3];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage H: hit classification, magnitude of t
    logic signed [DW-1:0] lim;
    logic signed [DW:0]   uv_sum;
    logic                 par_miss;
    logic                 u_miss;
    logic                 v_miss;
    status_t              status_next;
    status_t              h_status_reg;
    logic [DW-1:0]        h_det_reg;
    logic [DW-1:0]        h_un_reg;
    logic [DW-1:0]        h_vn_reg;
    logic [DW-1:0]        h_tabs_reg;
    logic                 h_tneg_reg;

    always_comb
    begin
        lim      = $signed({{(DW-THR_W){1'b0}}, thr_reg}) <<< (2 * FRAC_BITS);
        uv_sum   = (DW+1)'(g_un_reg) + (DW+1)'(g_vn_reg);
        par_miss = (g_det_reg == '0) || (g_det_reg < lim);
        u_miss   = g_un_reg[DW-1] || (g_un_reg > g_det_reg);
        v_miss   = g_vn_reg[DW-1] || (uv_sum > (DW+1)'(g_det_reg));
        if (par_miss)
            status_next = ST_PARALLEL;
        else if (u_miss)
            status_next = ST_U_OUT;
        else if (v_miss)
            status_next = ST_V_OUT;
        else
            status_next = ST_HIT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_status_reg <= status_next;
            h_det_reg    <= g_det_reg;
            h_un_reg     <= g_un_reg;
            h_vn_reg     <= g_vn_reg;
            h_tabs_reg   <= g_tn_reg[DW-1] ? -g_tn_reg : g_tn_reg;
            h_tneg_reg   <= g_tn_reg[DW-1];
        end
    end

    // ------------------------------------------------------------------
    // divider: one restoring step per stage for t, u and v in parallel
    logic [RW-1:0] dv_rt_reg [QB];
    logic [RW-1:0] dv_ru_reg [QB];
    logic [RW-1:0] dv_rv_reg [QB];
    logic [QB-1:0] dv_qt_reg [QB];
    logic [QB-1:0] dv_qu_reg [QB];
    logic [QB-1:0] dv_qv_reg [QB];
    logic [DW-1:0] dv_det_reg [QB];
    status_t       dv_status_reg [QB];
    logic          dv_tneg_reg [QB];
    logic          dv_ovf_reg [QB];

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int K = QB - 1 - j;
        logic [RW-1:0] rt_in;
        logic [RW-1:0] ru_in;
        logic [RW-1:0] rv_in;
        logic [QB-1:0] qt_in;
        logic [QB-1:0] qu_in;
        logic [QB-1:0] qv_in;
        logic [DW-1:0] det_in;
        status_t       status_in;
        logic          tneg_in;
        logic          ovf_in;
        logic [RW-1:0] dsh;
        logic          bt;
        logic          bu;
        logic          bv;

        if (j == 0)
        begin : g_first
            assign rt_in     = {{(RW-DW){1'b0}}, h_tabs_reg} << FRAC_BITS;
            assign ru_in     = {{(RW-DW){1'b0}}, h_un_reg} << FRAC_BITS;
            assign rv_in     = {{(RW-DW){1'b0}}, h_vn_reg} << FRAC_BITS;
            assign qt_in     = '0;
            assign qu_in     = '0;
            assign qv_in     = '0;
            assign det_in    = h_det_reg;
            assign status_in = h_status_reg;
            assign tneg_in   = h_tneg_reg;
            // quotient of t needs more than QB bits
            assign ovf_in    = rt_in >= ({{(RW-DW){1'b0}}, h_det_reg} << QB);
        end
        else
        begin : g_next
            assign rt_in     = dv_rt_reg[j-1];
            assign ru_in     = dv_ru_reg[j-1];
            assign rv_in     = dv_rv_reg[j-1];
            assign qt_in     = dv_qt_reg[j-1];
            assign qu_in     = dv_qu_reg[j-1];
            assign qv_in     = dv_qv_reg[j-1];
            assign det_in    = dv_det_reg[j-1];
            assign status_in = dv_status_reg[j-1];
            assign tneg_in   = dv_tneg_reg[j-1];
            assign ovf_in    = dv_ovf_reg[j-1];
        end

        assign dsh = {{(RW-DW){1'b0}}, det_in} << K;
        assign bt  = rt_in >= dsh;
        assign bu  = ru_in >= dsh;
        assign bv  = rv_in >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rt_reg[j]     <= bt ? rt_in - dsh : rt_in;
                dv_ru_reg[j]     <= bu ? ru_in - dsh : ru_in;
                dv_rv_reg[j]     <= bv ? rv_in - dsh : rv_in;
                dv_qt_reg[j]     <= {qt_in[QB-2:0], bt};
                dv_qu_reg[j]     <= {qu_in[QB-2:0], bu};
                dv_qv_reg[j]     <= {qv_in[QB-2:0], bv};
                dv_det_reg[j]    <= det_in;
                dv_status_reg[j] <= status_in;
                dv_tneg_reg[j]   <= tneg_in;
                dv_ovf_reg[j]    <= ovf_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // result formatting: saturate t, clear fields on a miss
    logic [QB-1:0] mag;

    always_comb
    begin
        mag = dv_qt_reg[QB-1];
        rsp_next.status   = dv_status_reg[QB-1];
        rsp_next.distance = '0;
        rsp_next.bary_u   = '0;
        rsp_next.bary_v   = '0;
        if (dv_status_reg[QB-1] == ST_HIT)
        begin
            rsp_next.bary_u = dv_qu_reg[QB-1][BARY_W-1:0];
            rsp_next.bary_v = dv_qv_reg[QB-1][BARY_W-1:0];
            if (dv_tneg_reg[QB-1])
            begin
                if (dv_ovf_reg[QB-1] || (mag > NEG_LIMIT))
                    rsp_next.distance = DIST_MIN;
                else
                    rsp_next.distance = $signed(DATA_W'(0) - mag);
            end
            else
            begin
                if (dv_ovf_reg[QB-1] || mag[QB-1])
                    rsp_next.distance = DIST_MAX;
                else
                    rsp_next.distance = $signed(mag);
            end
        end
    end

    // two-entry output queue
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= rsp_next;
    end

    assign result.valid    = (cnt_reg != 2'd0);
    assign result.status   = fifo_reg[rd_ptr_reg].status;
    assign result.distance = fifo_reg[rd_ptr_reg].distance;
    assign result.bary_u   = fifo_reg[rd_ptr_reg].bary_u;
    assign result.bary_v   = fifo_reg[rd_ptr_reg].bary_v;

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for ray_triangle_intersect: directed table plus random rays/triangles.
`timescale 1ns / 1ps
module tb;
    import rti_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic                     op;
        logic signed [31:0]       crd [9];
        bit                       typed;
        status_t                  typed_status;
    } hit_item_t;

    localparam int ONE = 65536;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    rti_req_if request_ch ();
    rti_rsp_if result_ch ();

    ray_triangle_intersect u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request_ch),
        .result    (result_ch)
    );

    // predictor copy of held ray and threshold
    logic signed [31:0] held_origin [3];
    logic signed [31:0] held_dir [3];
    logic [THR_W-1:0]   cur_threshold;

    rsp_t      pending_results [$];
    hit_item_t directed_rows [$];
    int        fail_count;
    int        tx_idle;
    int        rx_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("ray_triangle_intersect: mismatch");
        $finish;
    end

    function automatic wide_t wx(input logic signed [31:0] x);
        wide_t w;
        w = x;
        return w;
    endfunction

    // Moller-Trumbore on exact wide integers
    function automatic rsp_t intersect_hit(input hit_item_t it);
        wide_t d [3], e [3], f [3], t [3], p [3], q [3];
        wide_t det, un, vn, tn, lim;
        logic [127:0] num, den, mag;
        rsp_t r;
        bit neg;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = wx(held_dir[i]);
            e[i] = wx(it.crd[3+i]) - wx(it.crd[i]);
            f[i] = wx(it.crd[6+i]) - wx(it.crd[i]);
            t[i] = wx(held_origin[i]) - wx(it.crd[i]);
        end
        p[0] = d[1]*f[2] - d[2]*f[1];
        p[1] = d[2]*f[0] - d[0]*f[2];
        p[2] = d[0]*f[1] - d[1]*f[0];
        q[0] = t[1]*e[2] - t[2]*e[1];
        q[1] = t[2]*e[0] - t[0]*e[2];
        q[2] = t[0]*e[1] - t[1]*e[0];
        det = p[0]*e[0] + p[1]*e[1] + p[2]*e[2];
        un  = p[0]*t[0] + p[1]*t[1] + p[2]*t[2];
        vn  = q[0]*d[0] + q[1]*d[1] + q[2]*d[2];
        tn  = q[0]*f[0] + q[1]*f[1] + q[2]*f[2];
        if (det < 0)
        begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        r.status   = ST_HIT;
        r.distance = '0;
        r.bary_u   = '0;
        r.bary_v   = '0;
        lim = wide_t'(cur_threshold) <<< 32;
        if (det == 0 || det < lim)
            r.status = ST_PARALLEL;
        else if (un < 0 || un > det)
            r.status = ST_U_OUT;
        else if (vn < 0 || un + vn > det)
            r.status = ST_V_OUT;
        else
        begin
            neg = tn < 0;
            num = neg ? -tn : tn;
            den = det;
            mag = (num << 16) / den;
            if (neg)
                r.distance = (mag > 128'h8000_0000) ? DIST_MIN : -$signed(mag[31:0]);
            else
                r.distance = (mag > 128'h7FFF_FFFF) ? DIST_MAX : mag[31:0];
            num = un;
            mag = (num << 16) / den;
            r.bary_u = mag[16:0];
            num = vn;
            mag = (num << 16) / den;
            r.bary_v = mag[16:0];
        end
        return r;
    endfunction

    // drive one item and update the predictor on accept
    task automatic send_item(input hit_item_t it);
        rsp_t r;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid    <= 1'b1;
        request_ch.op       <= it.op;
        request_ch.first_x  <= it.crd[0];
        request_ch.first_y  <= it.crd[1];
        request_ch.first_z  <= it.crd[2];
        request_ch.second_x <= it.crd[3];
        request_ch.second_y <= it.crd[4];
        request_ch.second_z <= it.crd[5];
        request_ch.third_x  <= it.crd[6];
        request_ch.third_y  <= it.crd[7];
        request_ch.third_z  <= it.crd[8];
        // ready is settled mid-cycle; the item goes in at the following rising edge
        @(negedge clk);
        while (!request_ch.ready)
            @(negedge clk);
        @(posedge clk);
        if (it.op == OP_RAY)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_origin[i] = it.crd[i];
                held_dir[i]    = it.crd[3+i];
            end
        end
        else if (it.typed)
        begin
            r.status   = it.typed_status;
            r.distance = '0;
            r.bary_u   = '0;
            r.bary_v   = '0;
            pending_results.push_back(r);
        end
        else
            pending_results.push_back(intersect_hit(it));
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] v);
        request_ch.valid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we        <= 1'b0;
        cur_threshold  = v;
    endtask

    task automatic add_row(input logic op, input int v0, v1, v2, v3, v4, v5, v6, v7, v8,
                           input bit typed, input status_t st);
        hit_item_t it;
        it.op = op;
        it.crd[0] = v0; it.crd[1] = v1; it.crd[2] = v2;
        it.crd[3] = v3; it.crd[4] = v4; it.crd[5] = v5;
        it.crd[6] = v6; it.crd[7] = v7; it.crd[8] = v8;
        it.typed = typed;
        it.typed_status = st;
        directed_rows.push_back(it);
    endtask

    function automatic int small_val(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // ray mostly aimed roughly at +z, triangles mostly in a plane near its path; some fully random
    task automatic random_burst();
        hit_item_t it;
        int ox, oy, zc, span, n;
        it.typed = 1'b0;
        it.typed_status = ST_HIT;
        if ($urandom_range(0, 9) < 2)
        begin
            it.op = OP_RAY;
            for (int i = 0; i < 9; i++)
                it.crd[i] = $urandom;
            send_item(it);
        end
        else
        begin
            ox = small_val(1 << 18);
            oy = small_val(1 << 18);
            it.op = OP_RAY;
            it.crd[0] = ox;
            it.crd[1] = oy;
            it.crd[2] = -int'($urandom_range(1, 1 << 20));
            it.crd[3] = small_val(1 << 12);
            it.crd[4] = small_val(1 << 12);
            it.crd[5] = ($urandom_range(0, 7) == 0) ? -int'($urandom_range(1 << 14, 1 << 18))
                                                      : int'($urandom_range(1 << 14, 1 << 18));
            it.crd[6] = $urandom; it.crd[7] = $urandom; it.crd[8] = $urandom;
            send_item(it);
        end
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
        begin
            it.op = OP_TRI;
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    for (int i = 0; i < 9; i++)
                        it.crd[i] = $urandom;
                end
                3:
                begin
                    // degenerate: all vertices equal
                    it.crd[0] = $urandom; it.crd[1] = $urandom; it.crd[2] = $urandom;
                    for (int i = 3; i < 9; i++)
                        it.crd[i] = it.crd[i % 3];
                end
                default:
                begin
                    span = 1 << $urandom_range(10, 19);
                    zc = small_val(1 << 20);
                    it.crd[0] = ox - int'($urandom_range(0, span));
                    it.crd[1] = oy - int'($urandom_range(0, span));
                    it.crd[2] = zc + small_val(1 << 12);
                    it.crd[3] = ox + int'($urandom_range(0, span));
                    it.crd[4] = oy - int'($urandom_range(0, span));
                    it.crd[5] = zc + small_val(1 << 12);
                    it.crd[6] = ox + small_val(span);
                    it.crd[7] = oy + int'($urandom_range(0, span));
                    it.crd[8] = zc + small_val(1 << 12);
                end
            endcase
            send_item(it);
        end
    endtask

    // result checker, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, result_ch.status);
                    fail_count++;
                end
                if (result_ch.distance !== want.distance)
                begin
                    $error("distance expected %0d got %0d", want.distance, result_ch.distance);
                    fail_count++;
                end
                if (result_ch.bary_u !== want.bary_u)
                begin
                    $error("bary_u expected %0d got %0d", want.bary_u, result_ch.bary_u);
                    fail_count++;
                end
                if (result_ch.bary_v !== want.bary_v)
                begin
                    $error("bary_v expected %0d got %0d", want.bary_v, result_ch.bary_v);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= rx_idle);

    // main sequence
    initial
    begin
        logic [THR_W-1:0] thr_list [6];
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        fail_count = 0;
        tx_idle    = 34;
        rx_idle    = 65;
        request_ch.valid    = 1'b0;
        request_ch.op       = OP_RAY;
        request_ch.first_x  = '0; request_ch.first_y  = '0; request_ch.first_z  = '0;
        request_ch.second_x = '0; request_ch.second_y = '0; request_ch.second_z = '0;
        request_ch.third_x  = '0; request_ch.third_y  = '0; request_ch.third_z  = '0;
        result_ch.ready     = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            held_origin[i] = '0;
            held_dir[i]    = '0;
        end
        cur_threshold = 16'd1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // triangle before any ray: reset ray is all zero
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1, ST_PARALLEL);
        add_row(OP_TRI, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                1, ST_PARALLEL);
        // ray from z=-1 toward +z
        add_row(OP_RAY, ONE/4, ONE/4, -ONE, 0, 0, ONE, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        // degenerate triangle
        add_row(OP_TRI, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE,
                1, ST_PARALLEL);
        // through vertex A: u = v = 0
        add_row(OP_RAY, 0, 0, -ONE, 0, 0, ONE, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        // through vertex B: u = 1
        add_row(OP_RAY, ONE, 0, -ONE, 0, 0, 2*ONE, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        // midpoint of BC: u + v = 1
        add_row(OP_RAY, ONE/2, ONE/2, ONE, 0, 0, -ONE, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        // u outside, v outside, u + v above one
        add_row(OP_RAY, -ONE, ONE/4, -ONE, 0, 0, ONE, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        add_row(OP_RAY, ONE/4, -ONE, -ONE, 0, 0, ONE, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        add_row(OP_RAY, ONE, ONE, -ONE, 0, 0, ONE, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        // ray parallel to the plane
        add_row(OP_RAY, 0, 0, ONE, ONE, 0, 0, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        // hit behind the origin, tiny direction for saturation
        add_row(OP_RAY, ONE/4, ONE/4, ONE, 0, 0, 1, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ST_HIT);
        // extreme ray and triangle
        add_row(OP_RAY, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, ST_HIT);
        add_row(OP_TRI, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                0, ST_HIT);
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // random phases over several thresholds and idle patterns
        thr_list[0] = 16'd0;
        thr_list[1] = 16'hFFFF;
        thr_list[2] = $urandom_range(1, 255);
        thr_list[3] = 16'd1;
        thr_list[4] = $urandom;
        thr_list[5] = 16'd0;
        for (int ph = 0; ph < 6; ph++)
        begin
            set_threshold(thr_list[ph]);
            case (ph / 2)
                0: begin tx_idle = 34; rx_idle = 65; end
                1: begin tx_idle = 65; rx_idle = 34; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            for (int b = 0; b < 60; b++)
                random_burst();
        end
        request_ch.valid <= 1'b0;
        wait_drained();

        if (fail_count == 0)
            $display("ray_triangle_intersect: match");
        else
            $display("ray_triangle_intersect: mismatch");
        $finish;
    end
endmodule
